// ----- sv/process_state_manager_defines.svh -----
// Assertion macros for the checker file.
// They expect clk and arst_n in scope.
`ifndef PROCESS_STATE_MANAGER_DEFINES_SVH
`define PROCESS_STATE_MANAGER_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define PSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	`PSM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- sv/psm_pkg.sv -----
package psm_pkg;

	// request codes
	localparam logic [2:0] REQ_CREATE   = 3'd0;
	localparam logic [2:0] REQ_DISPATCH = 3'd1;
	localparam logic [2:0] REQ_TICK     = 3'd2;
	localparam logic [2:0] REQ_BLOCK    = 3'd3;
	localparam logic [2:0] REQ_WAKE     = 3'd4;
	localparam logic [2:0] REQ_EXIT     = 3'd5;
	localparam logic [2:0] REQ_KILL     = 3'd6;

	// process states
	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_READY   = 3'd1;
	localparam logic [2:0] ST_RUNNING = 3'd2;
	localparam logic [2:0] ST_WAITING = 3'd3;
	localparam logic [2:0] ST_TERM    = 3'd4;

	// status codes
	localparam logic [3:0] ERR_OK          = 4'd0;
	localparam logic [3:0] ERR_DUPLICATE   = 4'd1;
	localparam logic [3:0] ERR_CPU_BUSY    = 4'd2;
	localparam logic [3:0] ERR_NONE_READY  = 4'd3;
	localparam logic [3:0] ERR_NONE_RUN    = 4'd4;
	localparam logic [3:0] ERR_NOT_RUNNING = 4'd5;
	localparam logic [3:0] ERR_NOT_WAITING = 4'd6;
	localparam logic [3:0] ERR_NO_SUCH     = 4'd7;
	localparam logic [3:0] ERR_TERMINATED  = 4'd8;
	localparam logic [3:0] ERR_FULL        = 4'd9;

	// kill source codes
	localparam logic [1:0] REM_NONE  = 2'd0;
	localparam logic [1:0] REM_CPU   = 2'd1;
	localparam logic [1:0] REM_READY = 2'd2;
	localparam logic [1:0] REM_WAIT  = 2'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  name_key;
		logic [7:0]  priority_req;
		logic [15:0] tick_amount;
	} psm_req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  pid;
		logic [7:0]  affected_name;
		logic [2:0]  old_state;
		logic [2:0]  new_state;
		logic [1:0]  removed_from;
		logic [31:0] prog_counter;
		logic [31:0] cpu_time;
	} psm_res_t;

	// one row of the process table
	typedef struct packed {
		logic [7:0]  name;
		logic [2:0]  state;
		logic [31:0] pc;
		logic [31:0] cpu;
	} psm_entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture command
		logic scan_clr;   // restart name scan
		logic scan_inc;   // next scan entry
		logic rd_scan;    // read entry at scan index
		logic rd_run;     // read running entry
		logic set_found;  // scanned entry matches
		logic pop;        // read and drop ready queue head
		logic rd_head;    // read entry named by popped head
		logic commit;     // finish command, emit result
	} psm_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] req;
		logic       scan_end;
		logic       name_hit;
		logic       running;
		logic       live_zero;
		logic       head_ready;
	} psm_sts_t;

endpackage

// ----- sv/process_state_manager.sv -----
// Channel   | Ports               | Transfer
// ----------+---------------------+-------------------------------
// command   | start, busy, cmd    | edge with start high, busy low
// result    | done, result        | edge ending the cycle done high
//
// One command at a time; busy stays high until its result is shown.
// Name lookups for create, wake and kill scan the table one entry at a time,
// each entry read, then its name compared; tick, block and exit read the running one.
// Dispatch pops queue slots until a ready entry turns up; killed ones are skipped.
// arst_n clears counters and the running slot; no clearing pass is needed.
// done is a one-cycle strobe; the receiver cannot stall it.
module process_state_manager #(
	parameter int TABLE_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  psm_pkg::psm_req_t  cmd,
	output logic               done,
	output psm_pkg::psm_res_t  result
);
	import psm_pkg::*;

	psm_ctl_t ctl;
	psm_sts_t sts;

	psm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	psm_dpath #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

// ----- sv/psm_ctrl.sv -----
module psm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  psm_pkg::psm_sts_t  sts,
	output psm_pkg::psm_ctl_t  ctl
);
	import psm_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DEC    = 3'd1;
	localparam logic [2:0] S_SREQ   = 3'd2;
	localparam logic [2:0] S_SCMP   = 3'd3;
	localparam logic [2:0] S_QRD    = 3'd4;
	localparam logic [2:0] S_QENT   = 3'd5;
	localparam logic [2:0] S_QCHK   = 3'd6;
	localparam logic [2:0] S_COMMIT = 3'd7;

	logic [2:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.req) inside
					REQ_CREATE, REQ_WAKE, REQ_KILL: begin
						ctl.scan_clr = 1'b1;
						state_d = S_SREQ;
					end
					REQ_DISPATCH: begin
						state_d = (sts.running || sts.live_zero) ? S_COMMIT : S_QRD;
					end
					REQ_TICK, REQ_BLOCK, REQ_EXIT: begin
						ctl.rd_run = sts.running;
						state_d = S_COMMIT;
					end
					default: state_d = S_COMMIT;
				endcase
			end
			S_SREQ: begin
				if (sts.scan_end) begin
					state_d = S_COMMIT;
				end else begin
					ctl.rd_scan = 1'b1;
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				if (sts.name_hit) begin
					ctl.set_found = 1'b1;
					state_d = S_COMMIT;
				end else begin
					ctl.scan_inc = 1'b1;
					state_d = S_SREQ;
				end
			end
			S_QRD: begin
				ctl.pop = 1'b1;
				state_d = S_QENT;
			end
			S_QENT: begin
				ctl.rd_head = 1'b1;
				state_d = S_QCHK;
			end
			// killed entries left in the queue are skipped
			S_QCHK: begin
				state_d = sts.head_ready ? S_COMMIT : S_QRD;
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/psm_dpath.sv -----
module psm_dpath #(
	parameter int TABLE_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  psm_pkg::psm_req_t  cmd,
	input  psm_pkg::psm_ctl_t  ctl,
	output psm_pkg::psm_sts_t  sts,
	output logic               done,
	output psm_pkg::psm_res_t  result
);
	import psm_pkg::*;

	localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam int PW = CW + 1;

	// storage
	psm_entry_t     ent_mem [TABLE_SIZE];
	logic [IW-1:0]  rq_mem  [TABLE_SIZE];

	psm_req_t       cmd_q;
	psm_entry_t     rd_q;
	logic [IW-1:0]  idx_q;
	logic [IW-1:0]  head_q;
	logic           found_q;
	logic [CW-1:0]  scan_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  live_q;
	logic [IW-1:0]  rq_head_q, rq_tail_q;
	logic           run_q;
	logic [IW-1:0]  run_idx_q;
	logic           done_q;
	psm_res_t       res_q;

	// commit decisions
	psm_res_t       res_d;
	logic           we;
	logic [IW-1:0]  waddr;
	psm_entry_t     wdata;
	logic           push;
	logic [IW-1:0]  push_idx;
	logic           cnt_inc, live_inc, live_dec, run_set, run_clr;
	logic [IW-1:0]  new_idx;
	logic [PW-1:0]  pid_w;
	logic [31:0]    amt32;

	assign new_idx = count_q[IW-1:0];
	assign amt32   = 32'(cmd_q.tick_amount);

	assign sts.req        = cmd_q.req_type;
	assign sts.scan_end   = (scan_q == count_q);
	assign sts.name_hit   = (rd_q.name == cmd_q.name_key);
	assign sts.running    = run_q;
	assign sts.live_zero  = (live_q == '0);
	assign sts.head_ready = (rd_q.state == ST_READY);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
		wrap_inc = (p == IW'(TABLE_SIZE - 1)) ? '0 : p + 1'b1;
	endfunction

	// outcome of the command
	always_comb begin
		res_d = '0;
		res_d.affected_name = cmd_q.name_key;
		we = 1'b0;
		waddr = idx_q;
		wdata = rd_q;
		push = 1'b0;
		push_idx = idx_q;
		cnt_inc = 1'b0;
		live_inc = 1'b0;
		live_dec = 1'b0;
		run_set = 1'b0;
		run_clr = 1'b0;
		pid_w = PW'(idx_q) + PW'(1);
		case (cmd_q.req_type) inside
			REQ_CREATE: begin
				if (found_q) begin
					res_d.status = ERR_DUPLICATE;
				end else if (count_q == CW'(TABLE_SIZE)) begin
					res_d.status = ERR_FULL;
				end else begin
					we = 1'b1;
					waddr = new_idx;
					wdata = '{name: cmd_q.name_key, state: ST_READY, pc: '0, cpu: '0};
					push = 1'b1;
					push_idx = new_idx;
					cnt_inc = 1'b1;
					live_inc = 1'b1;
					pid_w = PW'(count_q) + PW'(1);
					res_d.old_state = ST_NEW;
				end
			end
			REQ_DISPATCH: begin
				if (run_q) begin
					res_d.status = ERR_CPU_BUSY;
				end else if (live_q == '0) begin
					res_d.status = ERR_NONE_READY;
				end else begin
					we = 1'b1;
					wdata.state = ST_RUNNING;
					run_set = 1'b1;
					live_dec = 1'b1;
					res_d.old_state = ST_READY;
				end
			end
			REQ_TICK: begin
				if (!run_q) begin
					res_d.status = ERR_NONE_RUN;
				end else begin
					we = 1'b1;
					wdata.pc = rd_q.pc + amt32;
					wdata.cpu = rd_q.cpu + amt32;
					res_d.old_state = ST_RUNNING;
				end
			end
			REQ_BLOCK, REQ_EXIT: begin
				if (!run_q) begin
					res_d.status = ERR_NONE_RUN;
				end else if (rd_q.name != cmd_q.name_key) begin
					res_d.status = ERR_NOT_RUNNING;
				end else begin
					we = 1'b1;
					wdata.state = (cmd_q.req_type == REQ_BLOCK) ? ST_WAITING : ST_TERM;
					run_clr = 1'b1;
					res_d.old_state = ST_RUNNING;
				end
			end
			REQ_WAKE: begin
				if (!found_q || rd_q.state != ST_WAITING) begin
					res_d.status = ERR_NOT_WAITING;
				end else begin
					we = 1'b1;
					wdata.state = ST_READY;
					push = 1'b1;
					live_inc = 1'b1;
					res_d.old_state = ST_WAITING;
				end
			end
			REQ_KILL: begin
				if (!found_q) begin
					res_d.status = ERR_NO_SUCH;
				end else if (rd_q.state == ST_TERM) begin
					res_d.status = ERR_TERMINATED;
				end else begin
					we = 1'b1;
					wdata.state = ST_TERM;
					res_d.old_state = rd_q.state;
					if (run_q && run_idx_q == idx_q) begin
						run_clr = 1'b1;
						res_d.removed_from = REM_CPU;
					end else if (rd_q.state == ST_READY) begin
						// stays in the queue, skipped on dispatch
						live_dec = 1'b1;
						res_d.removed_from = REM_READY;
					end else if (rd_q.state == ST_WAITING) begin
						res_d.removed_from = REM_WAIT;
					end
				end
			end
			default: res_d.status = ERR_NO_SUCH;
		endcase
		if (we) begin
			res_d.pid = 8'(pid_w);
			res_d.affected_name = wdata.name;
			res_d.new_state = wdata.state;
			res_d.prog_counter = wdata.pc;
			res_d.cpu_time = wdata.cpu;
		end
	end

	// table and queue memories
	always_ff @(posedge clk) begin
		if (ctl.commit && we) begin
			ent_mem[waddr] <= wdata;
		end
		if (ctl.rd_scan) begin
			rd_q <= ent_mem[scan_q[IW-1:0]];
		end else if (ctl.rd_run) begin
			rd_q <= ent_mem[run_idx_q];
		end else if (ctl.rd_head) begin
			rd_q <= ent_mem[head_q];
		end
		if (ctl.commit && push) begin
			rq_mem[rq_tail_q] <= push_idx;
		end
		if (ctl.pop) begin
			head_q <= rq_mem[rq_head_q];
		end
	end

	// command and index capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
		end
		if (ctl.rd_scan) begin
			idx_q <= scan_q[IW-1:0];
		end else if (ctl.rd_run) begin
			idx_q <= run_idx_q;
		end else if (ctl.rd_head) begin
			idx_q <= head_q;
		end
		res_q <= res_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			scan_q    <= '0;
			count_q   <= '0;
			live_q    <= '0;
			rq_head_q <= '0;
			rq_tail_q <= '0;
			run_q     <= 1'b0;
			run_idx_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= ctl.commit;
			if (ctl.load) begin
				found_q <= 1'b0;
			end else if (ctl.set_found) begin
				found_q <= 1'b1;
			end
			if (ctl.scan_clr) begin
				scan_q <= '0;
			end else if (ctl.scan_inc) begin
				scan_q <= scan_q + 1'b1;
			end
			if (ctl.pop) begin
				rq_head_q <= wrap_inc(rq_head_q);
			end
			if (ctl.commit) begin
				if (cnt_inc) begin
					count_q <= count_q + 1'b1;
				end
				if (push) begin
					rq_tail_q <= wrap_inc(rq_tail_q);
				end
				if (live_inc) begin
					live_q <= live_q + 1'b1;
				end else if (live_dec) begin
					live_q <= live_q - 1'b1;
				end
				if (run_set) begin
					run_q <= 1'b1;
					run_idx_q <= idx_q;
				end else if (run_clr) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- sv/psm_checker.sv -----
`include "process_state_manager_defines.svh"

module psm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input psm_pkg::psm_res_t  result
);
	import psm_pkg::*;

	// a transfer always occupies the block
	`PSM_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised")
	// every command ends with a result
	`PSM_ASSERT(a_done_on_end, $fell(busy) |-> done, "command ended without result")
	// errors carry no pid
	`PSM_ASSERT(a_err_pid, done && result.status != ERR_OK |-> result.pid == 8'd0, "pid on error")
	// errors carry no state change
	`PSM_ASSERT(a_err_state, done && result.status != ERR_OK |-> result.old_state == ST_NEW && result.new_state == ST_NEW && result.removed_from == REM_NONE, "state on error")

endmodule

bind process_state_manager psm_checker u_psm_checker (.*);

// ----- tb/process_state_manager_test.sv -----
module process_state_manager_test;
	import psm_pkg::*;

	localparam int TBL = 16;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	psm_req_t cmd;
	logic done;
	psm_res_t result;

	process_state_manager #(.TABLE_SIZE(TBL)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	// shadow process table
	logic [7:0]  tbl_name [TBL];
	logic [2:0]  tbl_state [TBL];
	logic [31:0] tbl_pc [TBL];
	logic [31:0] tbl_cpu [TBL];
	int          tbl_count;
	int          ready_fifo [$];
	bit          cpu_valid;
	int          cpu_idx;

	psm_req_t pending_cmds [$];
	psm_res_t expected_results [$];
	int       fail_count;
	int       cycle_count;
	int       send_idle_pct;
	bit       stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_name(logic [7:0] key);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_name[i] == key) return i;
		return -1;
	endfunction

	function automatic psm_res_t err_res(logic [3:0] code, logic [7:0] key);
		psm_res_t r;
		r = '0;
		r.status = code;
		r.affected_name = key;
		return r;
	endfunction

	function automatic psm_res_t ok_res(int idx, logic [2:0] old_st, logic [1:0] rem);
		psm_res_t r;
		r.status = ERR_OK;
		r.pid = 8'(idx + 1);
		r.affected_name = tbl_name[idx];
		r.old_state = old_st;
		r.new_state = tbl_state[idx];
		r.removed_from = rem;
		r.prog_counter = tbl_pc[idx];
		r.cpu_time = tbl_cpu[idx];
		return r;
	endfunction

	// apply one command to the shadow table and return the expected result
	function automatic psm_res_t predict_command(psm_req_t c);
		int idx;
		int pos;
		logic [2:0] old_st;
		logic [1:0] rem;
		case (c.req_type)
			REQ_CREATE: begin
				if (find_name(c.name_key) >= 0) return err_res(ERR_DUPLICATE, c.name_key);
				if (tbl_count >= TBL) return err_res(ERR_FULL, c.name_key);
				idx = tbl_count++;
				tbl_name[idx] = c.name_key;
				tbl_state[idx] = ST_READY;
				tbl_pc[idx] = '0;
				tbl_cpu[idx] = '0;
				ready_fifo.push_back(idx);
				return ok_res(idx, ST_NEW, REM_NONE);
			end
			REQ_DISPATCH: begin
				if (cpu_valid) return err_res(ERR_CPU_BUSY, c.name_key);
				if (ready_fifo.size() == 0) return err_res(ERR_NONE_READY, c.name_key);
				idx = ready_fifo.pop_front();
				tbl_state[idx] = ST_RUNNING;
				cpu_valid = 1'b1;
				cpu_idx = idx;
				return ok_res(idx, ST_READY, REM_NONE);
			end
			REQ_TICK: begin
				if (!cpu_valid) return err_res(ERR_NONE_RUN, c.name_key);
				tbl_pc[cpu_idx] += 32'(c.tick_amount);
				tbl_cpu[cpu_idx] += 32'(c.tick_amount);
				return ok_res(cpu_idx, ST_RUNNING, REM_NONE);
			end
			REQ_BLOCK, REQ_EXIT: begin
				if (!cpu_valid) return err_res(ERR_NONE_RUN, c.name_key);
				if (tbl_name[cpu_idx] != c.name_key)
					return err_res(ERR_NOT_RUNNING, c.name_key);
				tbl_state[cpu_idx] = (c.req_type == REQ_BLOCK) ? ST_WAITING : ST_TERM;
				cpu_valid = 1'b0;
				return ok_res(cpu_idx, ST_RUNNING, REM_NONE);
			end
			REQ_WAKE: begin
				idx = find_name(c.name_key);
				if (idx < 0 || tbl_state[idx] != ST_WAITING)
					return err_res(ERR_NOT_WAITING, c.name_key);
				tbl_state[idx] = ST_READY;
				ready_fifo.push_back(idx);
				return ok_res(idx, ST_WAITING, REM_NONE);
			end
			REQ_KILL: begin
				idx = find_name(c.name_key);
				if (idx < 0) return err_res(ERR_NO_SUCH, c.name_key);
				old_st = tbl_state[idx];
				if (old_st == ST_TERM) return err_res(ERR_TERMINATED, c.name_key);
				rem = REM_NONE;
				pos = -1;
				foreach (ready_fifo[i])
					if (pos < 0 && ready_fifo[i] == idx) pos = i;
				if (cpu_valid && cpu_idx == idx) begin
					cpu_valid = 1'b0;
					rem = REM_CPU;
				end else if (pos >= 0) begin
					ready_fifo.delete(pos);
					rem = REM_READY;
				end else if (old_st == ST_WAITING) begin
					rem = REM_WAIT;
				end
				tbl_state[idx] = ST_TERM;
				return ok_res(idx, old_st, rem);
			end
			default: return err_res(ERR_NO_SUCH, c.name_key);
		endcase
	endfunction

	// driver: one transfer per edge with start high and busy low
	always @(negedge clk) begin
		if (arst_n && !(start && busy)) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				start <= 1'b1;
				cmd <= pending_cmds[0];
			end else begin
				start <= 1'b0;
				cmd <= psm_req_t'($urandom);
			end
		end
	end

	// command transfer: predict at the accepting edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_results.push_back(predict_command(cmd));
			void'(pending_cmds.pop_front());
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		psm_res_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, result.status); fail_count++;
				end
				if (result.pid !== exp_r.pid) begin
					$error("pid exp %0d got %0d", exp_r.pid, result.pid); fail_count++;
				end
				if (result.affected_name !== exp_r.affected_name) begin
					$error("affected_name exp %0d got %0d", exp_r.affected_name,
						result.affected_name); fail_count++;
				end
				if (result.old_state !== exp_r.old_state) begin
					$error("old_state exp %0d got %0d", exp_r.old_state, result.old_state);
					fail_count++;
				end
				if (result.new_state !== exp_r.new_state) begin
					$error("new_state exp %0d got %0d", exp_r.new_state, result.new_state);
					fail_count++;
				end
				if (result.removed_from !== exp_r.removed_from) begin
					$error("removed_from exp %0d got %0d", exp_r.removed_from,
						result.removed_from); fail_count++;
				end
				if (result.prog_counter !== exp_r.prog_counter) begin
					$error("prog_counter exp %0h got %0h", exp_r.prog_counter,
						result.prog_counter); fail_count++;
				end
				if (result.cpu_time !== exp_r.cpu_time) begin
					$error("cpu_time exp %0h got %0h", exp_r.cpu_time, result.cpu_time);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic psm_req_t make_cmd(logic [2:0] op, logic [7:0] key,
			logic [7:0] prio, logic [15:0] amt);
		psm_req_t c;
		c.req_type = op;
		c.name_key = key;
		c.priority_req = prio;
		c.tick_amount = amt;
		return c;
	endfunction

	// random content, biased toward names already in use
	function automatic psm_req_t rand_cmd(ref logic [7:0] pool [$]);
		logic [2:0] op;
		logic [7:0] key;
		int r;
		r = $urandom_range(99);
		if (r < 18) op = REQ_CREATE;
		else if (r < 38) op = REQ_DISPATCH;
		else if (r < 58) op = REQ_TICK;
		else if (r < 70) op = REQ_BLOCK;
		else if (r < 82) op = REQ_WAKE;
		else if (r < 89) op = REQ_EXIT;
		else if (r < 97) op = REQ_KILL;
		else op = 3'd7;
		if (pool.size() > 0 && $urandom_range(9) < 8)
			key = pool[$urandom_range(pool.size() - 1)];
		else
			key = 8'($urandom);
		if (op == REQ_CREATE) pool.push_back(key);
		return make_cmd(op, key, 8'($urandom), 16'($urandom));
	endfunction

	task automatic drain();
		while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (4 + 2 * TBL + 3 * TBL) @(posedge clk);
	endtask

	initial begin
		logic [7:0] name_pool [$];
		int phase_pct [4];
		phase_pct = '{0, 63, 0, 19};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		tbl_count = 0;
		cpu_valid = 1'b0;
		cpu_idx = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: each command and each error path
		pending_cmds.push_back(make_cmd(REQ_DISPATCH, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_TICK, 8'hFF, 8'hFF, 16'hFFFF));
		pending_cmds.push_back(make_cmd(REQ_BLOCK, 8'h01, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_KILL, 8'h55, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_CREATE, 8'h00, 8'hFF, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_CREATE, 8'hFF, 8'h00, 16'hFFFF));
		pending_cmds.push_back(make_cmd(REQ_CREATE, 8'h00, 8'h12, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_DISPATCH, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_DISPATCH, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_TICK, 8'h00, 8'h00, 16'hFFFF));
		pending_cmds.push_back(make_cmd(REQ_EXIT, 8'hFF, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_WAKE, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_BLOCK, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_WAKE, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_KILL, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_KILL, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_CREATE, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_DISPATCH, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_KILL, 8'hFF, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(3'd7, 8'hAA, 8'h55, 16'h5555));
		pending_cmds.push_back(make_cmd(REQ_EXIT, 8'h33, 8'h00, 16'h0000));
		for (int i = 0; i < 15; i++)
			pending_cmds.push_back(make_cmd(REQ_CREATE, 8'(8'h10 + i), 8'(i), 16'h0));
		pending_cmds.push_back(make_cmd(REQ_DISPATCH, 8'h00, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_KILL, 8'h10, 8'h00, 16'h0000));
		pending_cmds.push_back(make_cmd(REQ_EXIT, 8'h00, 8'h00, 16'h0000));
		drain();

		// random: the phases share one table (reset happens once, so the full
		// table of the directed part stays; refill only matters for names)
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_pct[ph];
			for (int n = 0; n < 450; n++)
				pending_cmds.push_back(rand_cmd(name_pool));
			drain();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
